>>> hdl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the scope frame CRC-16 packer
// Widths, frame constants, the cell control struct and the CRC byte step.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int CH_W      = 16;
    localparam int NUM_CH    = 4;
    localparam int BYTE_W    = 8;
    localparam int DATA_LEN  = 8;
    localparam int FRAME_LEN = 10;
    localparam int POS_W     = 4;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(DATA_LEN);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(DATA_LEN + 1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // One byte through the reflected CRC-16/MODBUS register.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

>>> hdl/spc_cell.sv
// ----------------------------------------------------------------------------
// spc_cell: one byte cell of the frame shift chain
// Loads its own data byte when a sample set arrives and takes its neighbour's
// byte whenever the head of the chain is sent.
// ----------------------------------------------------------------------------
module spc_cell (
    input  logic                      clk,
    input  spc_pkg::cell_ctrl_t       ctrl,
    input  logic [spc_pkg::BYTE_W-1:0] load_byte,
    input  logic [spc_pkg::BYTE_W-1:0] neighbour_byte,
    output logic [spc_pkg::BYTE_W-1:0] byte_q
);
    import spc_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.load)
        begin
            byte_next = load_byte;
        end
        else if (ctrl.shift)
        begin
            byte_next = neighbour_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

>>> hdl/spc_crc.sv
// ----------------------------------------------------------------------------
// spc_crc: running CRC-16/MODBUS accumulator
// Seeds on a new frame and folds in each data byte as it leaves the chain.
// ----------------------------------------------------------------------------
module spc_crc (
    input  logic                       clk,
    input  spc_pkg::cell_ctrl_t        ctrl,
    input  logic [spc_pkg::BYTE_W-1:0] data_byte,
    output logic [15:0]                crc_q
);
    import spc_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.load)
        begin
            crc_next = CRC_SEED;
        end
        else if (ctrl.shift)
        begin
            crc_next = crc_byte(crc_reg, data_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign crc_q = crc_reg;

endmodule

>>> hdl/scope_frame_crc16_packer_core.sv
// ----------------------------------------------------------------------------
// scope_frame_crc16_packer_core: serial oscilloscope frame packer
// Turns one sample set of four channels into a ten-byte frame with a
// CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Each item on the slave side carries four 16-bit channel values. The block
// sends ten bytes on the master side: each channel low byte first, in channel
// order, then the CRC low and high bytes, with tlast on the tenth byte.
// The eight data bytes sit in a chain of byte cells that shifts by one each
// time a data byte is taken; the CRC is folded in one byte per cycle as the
// data leaves the chain, and both hold while the receiver stalls.
// The first byte is offered in the cycle after the item is accepted. No new
// item is accepted while a frame is in progress, but the next item is accepted
// in the same cycle as the final byte of the frame is taken, so frames follow
// one another with no gap.
// When the receiver stalls the current byte is held and nothing shifts.
// Reset empties the block; no frame is in progress afterwards.
// ----------------------------------------------------------------------------
module scope_frame_crc16_packer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [spc_pkg::NUM_CH*spc_pkg::CH_W-1:0] s_tdata,  // channel_a, channel_b, channel_c, channel_d
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // frame_byte
    output logic        m_tlast   // last_byte
);
    import spc_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             in_fire;
    logic             out_fire;
    logic             frame_done;
    cell_ctrl_t       cell_ctrl;
    cell_ctrl_t       crc_ctrl;
    logic [BYTE_W-1:0] cell_q [DATA_LEN];
    logic [15:0]      crc_q;

    assign out_fire   = busy_reg && m_tready;
    assign frame_done = out_fire && (pos_reg == POS_LAST);
    assign s_tready   = !busy_reg || frame_done;
    assign in_fire    = s_tvalid && s_tready;

    assign cell_ctrl.load  = in_fire;
    assign cell_ctrl.shift = out_fire && (pos_reg < POS_CRC_LO);
    assign crc_ctrl        = cell_ctrl;

    genvar gi;
    generate
        for (gi = 0; gi < DATA_LEN; gi++)
        begin : g_cell
            logic [BYTE_W-1:0] neighbour;
            if (gi == DATA_LEN - 1)
            begin : g_tail
                assign neighbour = '0;
            end
            else
            begin : g_body
                assign neighbour = cell_q[gi+1];
            end
            spc_cell u_cell (
                .clk            (clk),
                .ctrl           (cell_ctrl),
                .load_byte      (s_tdata[gi*BYTE_W +: BYTE_W]),
                .neighbour_byte (neighbour),
                .byte_q         (cell_q[gi])
            );
        end
    endgenerate

    spc_crc u_crc (
        .clk       (clk),
        .ctrl      (crc_ctrl),
        .data_byte (cell_q[0]),
        .crc_q     (crc_q)
    );

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (out_fire)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_LAST)
            begin
                busy_next = 1'b0;
            end
        end
        if (in_fire)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_comb
    begin
        if (pos_reg == POS_CRC_LO)
        begin
            m_tdata = crc_q[7:0];
        end
        else if (pos_reg == POS_CRC_HI)
        begin
            m_tdata = crc_q[15:8];
        end
        else
        begin
            m_tdata = cell_q[0];
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (pos_reg == POS_LAST);

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the scope frame CRC-16 packer
// Sends sample sets of four channels, predicts each ten-byte frame with a
// bit-serial CRC-16/MODBUS and checks every byte and tlast against it.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int RANDOM_SETS = 270;
    localparam int CYCLE_LIMIT = 250000;
    localparam int SETTLE_CYCLES = 20;
    localparam int CALM_FIRST = 100;
    localparam int CALM_LAST = 170;
    localparam int DRAIN_AT = 140;
    localparam int NUM_DIRECTED = 12;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    // Channel a sits in the lowest bits of each set.
    localparam logic [63:0] DIRECTED_SETS [NUM_DIRECTED] = '{
        {16'h0000, 16'h0000, 16'h0000, 16'h0000},
        {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        {16'h8000, 16'h8000, 16'h8000, 16'h8000},
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
        {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000},
        {16'h0000, 16'h0000, 16'h0000, 16'h0001},
        {16'h8000, 16'h0000, 16'h0000, 16'h0000},
        {16'h0708, 16'h0506, 16'h0304, 16'h0102},
        {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
        {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
        {16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF},
        {16'h7FFE, 16'h8001, 16'hABCD, 16'h1234}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    frame_byte_t pending_bytes[$];
    int          byte_errors;
    int          cycle_count;
    bit          steady_flow;

    scope_frame_crc16_packer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Frame bytes packed with byte k at bits 8k upwards; the CRC runs bit by bit.
    function automatic logic [79:0] pack_scope_frame(input logic [63:0] sample_set);
        logic [15:0] crc;
        logic        feedback;
        crc = CRC_SEED;
        for (int i = 0; i < 64; i++)
        begin
            feedback = crc[0] ^ sample_set[i];
            crc = crc >> 1;
            if (feedback)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return {crc, sample_set};
    endfunction

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        logic [79:0] frame;
        frame_byte_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                frame = pack_scope_frame(s_tdata);
                for (int k = 0; k < FRAME_LEN; k++)
                begin
                    pending_bytes.push_back('{frame[8*k +: 8], k == FRAME_LEN - 1});
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("frame_byte %02h arrived with no frame pending", m_tdata);
                    byte_errors++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        $error("frame_byte: expected %02h, got %02h", want.value, m_tdata);
                        byte_errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b", want.last, m_tlast);
                        byte_errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= steady_flow || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic offer_set(input logic [63:0] sample_set, input bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample_set;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        byte_errors = 0;
        cycle_count = 0;
        steady_flow = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_set(DIRECTED_SETS[i], 1'b1);
        end
        drain_frames();

        for (int i = 0; i < RANDOM_SETS; i++)
        begin
            steady_flow = (i >= CALM_FIRST) && (i <= CALM_LAST);
            if (i == DRAIN_AT)
            begin
                drain_frames();
            end
            if ($urandom_range(0, 1) == 0)
            begin
                offer_set({pick_channel(), pick_channel(), pick_channel(), pick_channel()},
                          !steady_flow);
            end
            else
            begin
                offer_set({$urandom, $urandom}, !steady_flow);
            end
        end
        steady_flow = 1'b0;

        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            $error("frame_byte: expected %0d more bytes, got none", pending_bytes.size());
            byte_errors++;
        end
        if (byte_errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
